>>> sv/gpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gait phase detector package
// Shared types, codes and sizes for the gait phase detector.
// ----------------------------------------------------------------------------
package gpd_pkg;

	// Field widths
	localparam int TIME_W    = 32;
	localparam int FORCE_W   = 24;
	localparam int THRESH_W  = 23;
	localparam int EVT_W     = 33;
	localparam int SQ_W      = 2 * FORCE_W - 1;
	localparam int NORM_W    = SQ_W + 2;
	localparam int THRSQ_W   = 2 * THRESH_W;

	// Default depth of the queue between classifier and tracker
	localparam int QUEUE_DEPTH_DEF = 4;

	// Event time or duration that is not known yet
	localparam logic [EVT_W-1:0] TIME_NONE = '1;

	// Per-leg contact phase
	typedef enum logic [1:0] {
		LEG_INVALID = 2'd0,
		LEG_SWING   = 2'd1,
		LEG_STANCE  = 2'd2
	} leg_phase_t;

	// Gait phase codes
	localparam logic [1:0] GAIT_DOUBLE      = 2'd0;
	localparam logic [1:0] GAIT_LEFT_SWING  = 2'd1;
	localparam logic [1:0] GAIT_RIGHT_SWING = 2'd2;
	localparam logic [1:0] GAIT_INVALID     = 2'd3;

	// Leading leg codes
	localparam logic [1:0] LEAD_NONE  = 2'd0;
	localparam logic [1:0] LEAD_RIGHT = 2'd1;
	localparam logic [1:0] LEAD_LEFT  = 2'd2;

	// Classified sample handed from front to back
	typedef struct packed {
		logic [TIME_W-1:0] sample_time;
		logic              right_stance;
		logic              left_stance;
	} sample_class_t;

	// Occupancy of the classifier pipeline
	typedef struct packed {
		logic busy_s1;
		logic busy_s2;
	} front_status_t;

endpackage

>>> sv/gait_phase_detector.sv
`timescale 1ns / 1ps
// An accepted sample passes the two-stage force classifier, a QUEUE_DEPTH-entry
// queue and the event tracker's result register. Throughput: one sample per cycle
// while the output is not stalled (full rate needs depth >= 4).
// Input ready counts queued and in-flight samples, so it drops only while
// the queue would fill under a stalled output.
// Reset clears event times and durations to -1, phases to invalid, threshold to 0.
// ----------------------------------------------------------------------------
// Gait phase detector
// Classifies each foot as stance or swing from its contact force and tracks
// heel strike and toe off events, support durations and the leading leg.
// ----------------------------------------------------------------------------
module gait_phase_detector
	import gpd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [THRESH_W-1:0]       cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [TIME_W-1:0]         sample_time,
	input  logic signed [FORCE_W-1:0] right_force_x,
	input  logic signed [FORCE_W-1:0] right_force_y,
	input  logic signed [FORCE_W-1:0] right_force_z,
	input  logic signed [FORCE_W-1:0] left_force_x,
	input  logic signed [FORCE_W-1:0] left_force_y,
	input  logic signed [FORCE_W-1:0] left_force_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                gait_phase,
	output logic [1:0]                leading_leg,
	output logic signed [EVT_W-1:0]   toe_off_time,
	output logic signed [EVT_W-1:0]   heel_strike_time,
	output logic signed [EVT_W-1:0]   double_support_time,
	output logic signed [EVT_W-1:0]   single_support_time,
	output logic                      detector_ready
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	front_status_t fstat;
	logic          push, pop, q_not_empty;
	sample_class_t push_data, pop_data;
	logic [CW-1:0] q_count;
	logic [CW:0]   used;

	// Reserve a queue slot for every beat in the classifier
	assign used = {1'b0, q_count} + (CW + 1)'(fstat.busy_s1) + (CW + 1)'(fstat.busy_s2);
	assign in_ready = used < (CW + 1)'(QUEUE_DEPTH);

	gpd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.take         (in_valid && in_ready),
		.sample_time  (sample_time),
		.right_force_x(right_force_x),
		.right_force_y(right_force_y),
		.right_force_z(right_force_z),
		.left_force_x (left_force_x),
		.left_force_y (left_force_y),
		.left_force_z (left_force_z),
		.status       (fstat),
		.push         (push),
		.push_data    (push_data)
	);

	gpd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.not_empty(q_not_empty),
		.pop_data (pop_data),
		.count    (q_count)
	);

	gpd_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.q_not_empty        (q_not_empty),
		.q_data             (pop_data),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.gait_phase         (gait_phase),
		.leading_leg        (leading_leg),
		.toe_off_time       (toe_off_time),
		.heel_strike_time   (heel_strike_time),
		.double_support_time(double_support_time),
		.single_support_time(single_support_time),
		.detector_ready     (detector_ready)
	);

endmodule

>>> sv/gpd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gait phase detector classifier
// Squares the force components, sums them per leg and compares each norm
// with the squared stance threshold. Two stages, one beat per cycle.
// ----------------------------------------------------------------------------
module gpd_front
	import gpd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [THRESH_W-1:0]        cfg_wdata,
	input  logic                       take,
	input  logic [TIME_W-1:0]          sample_time,
	input  logic signed [FORCE_W-1:0]  right_force_x,
	input  logic signed [FORCE_W-1:0]  right_force_y,
	input  logic signed [FORCE_W-1:0]  right_force_z,
	input  logic signed [FORCE_W-1:0]  left_force_x,
	input  logic signed [FORCE_W-1:0]  left_force_y,
	input  logic signed [FORCE_W-1:0]  left_force_z,
	output front_status_t              status,
	output logic                       push,
	output sample_class_t              push_data
);

	function automatic logic [SQ_W-1:0] square_force(input logic signed [FORCE_W-1:0] v);
		logic signed [2*FORCE_W-1:0] w;
		logic signed [2*FORCE_W-1:0] p;
		w = (2*FORCE_W)'(v);
		p = w * w;
		return p[SQ_W-1:0];
	endfunction

	logic [THRSQ_W-1:0] thr_sq_q;
	logic               valid_s1, valid_s2;
	logic [TIME_W-1:0]  time_s1, time_s2;
	logic [SQ_W-1:0]    rsq_s1 [3];
	logic [SQ_W-1:0]    lsq_s1 [3];
	logic               rst_s2, lst_s2;
	logic [NORM_W-1:0]  rnorm, lnorm;

	// Hold the squared threshold, squared once on each write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_sq_q <= '0;
		end else if (cfg_wen) begin
			thr_sq_q <= THRSQ_W'(cfg_wdata) * THRSQ_W'(cfg_wdata);
		end
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: square each component
	always_ff @(posedge clk) begin
		if (take) begin
			time_s1   <= sample_time;
			rsq_s1[0] <= square_force(right_force_x);
			rsq_s1[1] <= square_force(right_force_y);
			rsq_s1[2] <= square_force(right_force_z);
			lsq_s1[0] <= square_force(left_force_x);
			lsq_s1[1] <= square_force(left_force_y);
			lsq_s1[2] <= square_force(left_force_z);
		end
	end

	// Sum the squares per leg
	assign rnorm = NORM_W'(rsq_s1[0]) + NORM_W'(rsq_s1[1]) + NORM_W'(rsq_s1[2]);
	assign lnorm = NORM_W'(lsq_s1[0]) + NORM_W'(lsq_s1[1]) + NORM_W'(lsq_s1[2]);

	// Stage 2: compare with the threshold
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			time_s2 <= time_s1;
			rst_s2  <= rnorm > NORM_W'(thr_sq_q);
			lst_s2  <= lnorm > NORM_W'(thr_sq_q);
		end
	end

	assign status.busy_s1         = valid_s1;
	assign status.busy_s2         = valid_s2;
	assign push                   = valid_s2;
	assign push_data.sample_time  = time_s2;
	assign push_data.right_stance = rst_s2;
	assign push_data.left_stance  = lst_s2;

endmodule

>>> sv/gpd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gait phase detector queue
// Small circular queue of classified samples between classifier and tracker.
// ----------------------------------------------------------------------------
module gpd_queue
	import gpd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sample_class_t push_data,
	input  logic          pop,
	output logic          not_empty,
	output sample_class_t pop_data,
	output logic [CW-1:0] count
);

	sample_class_t   mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	// Write the incoming beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign not_empty = count_q != '0;
	assign pop_data  = mem[rd_ptr_q];
	assign count     = count_q;

endmodule

>>> sv/gpd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gait phase detector event tracker
// Detects heel strikes and toe offs, latches event times, forms support
// durations and drives the registered result beat.
// ----------------------------------------------------------------------------
module gpd_back
	import gpd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_not_empty,
	input  sample_class_t    q_data,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       gait_phase,
	output logic [1:0]       leading_leg,
	output logic [EVT_W-1:0] toe_off_time,
	output logic [EVT_W-1:0] heel_strike_time,
	output logic [EVT_W-1:0] double_support_time,
	output logic [EVT_W-1:0] single_support_time,
	output logic             detector_ready
);

	leg_phase_t       r_prev_q, l_prev_q;
	logic [EVT_W-1:0] toe_q, heel_q, ds_q, ss_q;
	logic [1:0]       lead_q;
	logic             out_valid_q;

	logic             hs_r, hs_l, to_r, to_l;
	leg_phase_t       r_now, l_now;
	logic [EVT_W-1:0] toe_n, heel_n, ds_n, ss_n;
	logic [1:0]       lead_n, phase_n;
	logic             ready_n;

	// Take a beat when the result register is free or being drained
	assign pop = q_not_empty && (!out_valid_q || out_ready);

	// Detect events and form the next state
	always_comb begin
		r_now = q_data.right_stance ? LEG_STANCE : LEG_SWING;
		l_now = q_data.left_stance ? LEG_STANCE : LEG_SWING;
		hs_r  = (r_prev_q == LEG_SWING) && q_data.right_stance;
		hs_l  = (l_prev_q == LEG_SWING) && q_data.left_stance;
		to_r  = (r_prev_q == LEG_STANCE) && !q_data.right_stance;
		to_l  = (l_prev_q == LEG_STANCE) && !q_data.left_stance;

		toe_n  = (to_r || to_l) ? {1'b0, q_data.sample_time} : toe_q;
		heel_n = (hs_r || hs_l) ? {1'b0, q_data.sample_time} : heel_q;

		ds_n = ds_q;
		if (!heel_n[EVT_W-1] && ($signed(toe_n) > $signed(heel_n))) begin
			ds_n = toe_n - heel_n;
		end
		ss_n = ss_q;
		if (!toe_n[EVT_W-1] && ($signed(heel_n) > $signed(toe_n))) begin
			ss_n = heel_n - toe_n;
		end

		lead_n = lead_q;
		if (hs_r) begin
			lead_n = LEAD_RIGHT;
		end else if (hs_l) begin
			lead_n = LEAD_LEFT;
		end

		case ({q_data.right_stance, q_data.left_stance})
			2'b11:   phase_n = GAIT_DOUBLE;
			2'b10:   phase_n = GAIT_LEFT_SWING;
			2'b01:   phase_n = GAIT_RIGHT_SWING;
			default: phase_n = GAIT_INVALID;
		endcase

		ready_n = !heel_n[EVT_W-1] && !toe_n[EVT_W-1] && !ds_n[EVT_W-1] &&
			!ss_n[EVT_W-1] && (lead_n != LEAD_NONE) && (phase_n != GAIT_INVALID);
	end

	// Hold tracker state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_prev_q    <= LEG_INVALID;
			l_prev_q    <= LEG_INVALID;
			toe_q       <= TIME_NONE;
			heel_q      <= TIME_NONE;
			ds_q        <= TIME_NONE;
			ss_q        <= TIME_NONE;
			lead_q      <= LEAD_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				r_prev_q    <= r_now;
				l_prev_q    <= l_now;
				toe_q       <= toe_n;
				heel_q      <= heel_n;
				ds_q        <= ds_n;
				ss_q        <= ss_n;
				lead_q      <= lead_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			gait_phase          <= phase_n;
			leading_leg         <= lead_n;
			toe_off_time        <= toe_n;
			heel_strike_time    <= heel_n;
			double_support_time <= ds_n;
			single_support_time <= ss_n;
			detector_ready      <= ready_n;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> sv/gpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gait phase detector checker
// Port-level checks on the result beats, bound to the top level.
// ----------------------------------------------------------------------------
module gpd_checker
	import gpd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [1:0]       gait_phase,
	input logic [1:0]       leading_leg,
	input logic [EVT_W-1:0] toe_off_time,
	input logic [EVT_W-1:0] heel_strike_time,
	input logic [EVT_W-1:0] double_support_time,
	input logic [EVT_W-1:0] single_support_time,
	input logic             detector_ready
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// Ready flag implies every field is known
	a_ready_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && detector_ready |-> gait_phase != GAIT_INVALID &&
		leading_leg != LEAD_NONE && !toe_off_time[EVT_W-1] &&
		!heel_strike_time[EVT_W-1] && !double_support_time[EVT_W-1] &&
		!single_support_time[EVT_W-1])
		else $error("detector ready with an unknown field");

	// A known double support needs both event times
	a_ds_times: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !double_support_time[EVT_W-1] |->
		!toe_off_time[EVT_W-1] && !heel_strike_time[EVT_W-1])
		else $error("double support known without both event times");

	// A known single support needs both event times
	a_ss_times: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !single_support_time[EVT_W-1] |->
		!toe_off_time[EVT_W-1] && !heel_strike_time[EVT_W-1])
		else $error("single support known without both event times");

	// Leading leg never takes the unused code
	a_lead_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> leading_leg == LEAD_NONE || leading_leg == LEAD_RIGHT ||
		leading_leg == LEAD_LEFT)
		else $error("leading leg holds an unused code");

endmodule

bind gait_phase_detector gpd_checker u_gpd_checker (.*);
